// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the normaliser RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Implication checked in the next clock cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ctpn_pkg.sv -----
// ----------------------------------------------------------------------------
// ctpn_pkg
// Shared constants, codes and command types for the two-point normaliser.
// ----------------------------------------------------------------------------
package ctpn_pkg;

   localparam int RAW_BITS_DEF    = 16;
   localparam int MAX_SAMPLES_DEF = 256;
   localparam int FRAC_BITS_DEF   = 15;

   localparam int OP_BITS   = 3;
   localparam int STAT_BITS = 3;
   localparam int CH_BITS   = 16;

   localparam logic [OP_BITS-1:0] OP_NORM   = 3'd0;
   localparam logic [OP_BITS-1:0] OP_WSAMP  = 3'd1;
   localparam logic [OP_BITS-1:0] OP_BSAMP  = 3'd2;
   localparam logic [OP_BITS-1:0] OP_WLOAD  = 3'd3;
   localparam logic [OP_BITS-1:0] OP_BLOAD  = 3'd4;

   localparam logic [STAT_BITS-1:0] ST_NORM   = 3'd0;
   localparam logic [STAT_BITS-1:0] ST_ACCUM  = 3'd1;
   localparam logic [STAT_BITS-1:0] ST_STORED = 3'd2;
   localparam logic [STAT_BITS-1:0] ST_OVER   = 3'd3;
   localparam logic [STAT_BITS-1:0] ST_LOADED = 3'd4;

   // controller -> datapath
   typedef struct packed {
      logic       capture;   // latch input transaction
      logic       accum;     // add sample to sums
      logic       load_w;    // load white ref from input
      logic       load_b;    // load black ref from input
      logic       div_start; // start divide on channel div_ch
      logic [1:0] div_ch;
      logic       div_avg;   // 1: average divide, 0: normalise
      logic       store_w;   // write quotient to white ref
      logic       store_b;   // write quotient to black ref
      logic       clear_run; // clear sums and count
      logic       out_load;  // present result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic over;
   } sts_type;

endpackage

// ----- hw/rtl/color_two_point_normalizer.sv -----
// ----------------------------------------------------------------------------
// color_two_point_normalizer
// Two-point black/white calibration and Q1.15 normalisation of RGB samples.
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  req     | req_valid/req_stall, opcode, *_raw, last     | in
//  rsp     | rsp_valid/rsp_stall, status, *_out           | out
//
// Normalise or final calibration sample: three divides in turn on one shared
// radix-2 divider, after which the result is offered.
// Other samples and loads offer their result the cycle after acceptance.
// One transaction is held at a time; req_stall is high until the result leaves.
// Reset (synchronous) zeroes both references and the calibration run.
// A stalled result holds on rsp_* until taken.
module color_two_point_normalizer
   import ctpn_pkg::*;
#(
   parameter int RAW_BITS    = RAW_BITS_DEF,
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_BITS-1:0]   req_opcode,
   input  logic [CH_BITS-1:0]   req_red_raw,
   input  logic [CH_BITS-1:0]   req_green_raw,
   input  logic [CH_BITS-1:0]   req_blue_raw,
   input  logic                 req_last_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STAT_BITS-1:0] rsp_status,
   output logic [CH_BITS-1:0]   rsp_red_out,
   output logic [CH_BITS-1:0]   rsp_green_out,
   output logic [CH_BITS-1:0]   rsp_blue_out
);
   cmd_type cmd;
   sts_type sts;

   // sequencer
   ctpn_control u_ctl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .cmd             (cmd),
      .sts             (sts)
   );

   // references, accumulator and divider
   ctpn_datapath #(
      .RAW_BITS    (RAW_BITS),
      .MAX_SAMPLES (MAX_SAMPLES),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_r       (req_red_raw),
      .in_g       (req_green_raw),
      .in_b       (req_blue_raw),
      .out_status (rsp_status),
      .out_r      (rsp_red_out),
      .out_g      (rsp_green_out),
      .out_b      (rsp_blue_out)
   );
endmodule

// ----- hw/rtl/ctpn_divider.sv -----
// ----------------------------------------------------------------------------
// ctpn_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctpn_divider
   import ctpn_pkg::*;
#(
   parameter int W = 40
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in;
   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic [W:0]    shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[W-1:0], quo_ff[W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial;
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ----- hw/rtl/ctpn_datapath.sv -----
// ----------------------------------------------------------------------------
// ctpn_datapath
// References, run accumulator, divider feed and result register.
// ----------------------------------------------------------------------------
module ctpn_datapath
   import ctpn_pkg::*;
#(
   parameter int RAW_BITS    = RAW_BITS_DEF,
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic [CH_BITS-1:0]   in_r,
   input  logic [CH_BITS-1:0]   in_g,
   input  logic [CH_BITS-1:0]   in_b,
   input  logic [STAT_BITS-1:0] out_status,
   output logic [CH_BITS-1:0]   out_r,
   output logic [CH_BITS-1:0]   out_g,
   output logic [CH_BITS-1:0]   out_b
);
   `include "assert_macros.svh"

   localparam int CNT_BITS = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_BITS = RAW_BITS + CNT_BITS;
   localparam int NUM_BITS = RAW_BITS + FRAC_BITS;
   localparam int DW = (SUM_BITS > NUM_BITS) ? SUM_BITS : NUM_BITS;
   localparam int RW = (RAW_BITS < CH_BITS) ? RAW_BITS : CH_BITS;

   logic [RAW_BITS-1:0] raw_ff  [3];
   logic [RAW_BITS-1:0] wref_ff [3];
   logic [RAW_BITS-1:0] bref_ff [3];
   logic [SUM_BITS-1:0] sum_ff  [3];
   logic [CNT_BITS-1:0] cnt_ff;
   logic [CH_BITS-1:0]  res_ff  [3];
   logic [CH_BITS-1:0]  res_in;
   logic [1:0]          ch_ff;
   logic                avg_ff;
   logic                skip_ff, skip_in;
   logic [DW-1:0]       dvd, dsr, quo;
   logic                ddone;
   logic [RAW_BITS-1:0] wsel, bsel, rsel;
   logic [RAW_BITS:0]   span, num, mag_d, mag_n;
   logic                neg;
   logic [RAW_BITS-1:0] raw_in [3];

   assign raw_in[0] = RAW_BITS'(in_r);
   assign raw_in[1] = RAW_BITS'(in_g);
   assign raw_in[2] = RAW_BITS'(in_b);

   always_comb begin
      wsel  = wref_ff[cmd.div_ch];
      bsel  = bref_ff[cmd.div_ch];
      rsel  = raw_ff[cmd.div_ch];
      span  = {1'b0, wsel} - {1'b0, bsel};
      num   = {1'b0, rsel} - {1'b0, bsel};
      mag_d = span[RAW_BITS] ? -span : span;
      mag_n = num[RAW_BITS] ? -num : num;
      neg   = (span != '0) && (num[RAW_BITS] != span[RAW_BITS]);
      if (cmd.div_avg) begin
         dvd     = DW'(sum_ff[cmd.div_ch]);
         dsr     = (cnt_ff == '0) ? DW'(1) : DW'(cnt_ff);
         skip_in = 1'b0;
      end else begin
         dvd     = DW'(mag_n) << FRAC_BITS;
         dsr     = DW'(mag_d);
         skip_in = (span == '0) || neg;
      end
   end

   ctpn_divider #(.W(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  ((cmd.div_start && skip_in) ? DW'(1) : dsr),
      .done     (ddone),
      .quotient (quo)
   );

   always_comb begin
      if (avg_ff) begin
         res_in = CH_BITS'(quo[RW-1:0]);
      end else if (skip_ff) begin
         res_in = '0;
      end else if (quo > (DW'(1) << FRAC_BITS)) begin
         res_in = CH_BITS'(DW'(1) << FRAC_BITS);
      end else begin
         res_in = CH_BITS'(quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            wref_ff[c] <= '0;
            bref_ff[c] <= '0;
            sum_ff[c]  <= '0;
         end
         cnt_ff <= '0;
      end else begin
         for (int c = 0; c < 3; c++) begin
            if (cmd.load_w) wref_ff[c] <= raw_in[c];
            if (cmd.load_b) bref_ff[c] <= raw_in[c];
            if (cmd.accum && !sts.over) sum_ff[c] <= sum_ff[c] + SUM_BITS'(raw_in[c]);
            if (cmd.clear_run) sum_ff[c] <= '0;
         end
         if (cmd.accum && !sts.over) cnt_ff <= cnt_ff + 1'b1;
         if (cmd.clear_run) cnt_ff <= '0;
         if (ddone && cmd.store_w) wref_ff[ch_ff] <= quo[RAW_BITS-1:0];
         if (ddone && cmd.store_b) bref_ff[ch_ff] <= quo[RAW_BITS-1:0];
      end
      if (cmd.capture) begin
         for (int c = 0; c < 3; c++) raw_ff[c] <= raw_in[c];
      end
      if (cmd.div_start) begin
         ch_ff   <= cmd.div_ch;
         avg_ff  <= cmd.div_avg;
         skip_ff <= skip_in;
      end
      if (ddone) res_ff[ch_ff] <= res_in;
      if (cmd.capture) begin
         for (int c = 0; c < 3; c++) res_ff[c] <= '0;
      end
   end

   assign sts.div_done = ddone;
   assign sts.over     = (32'(cnt_ff) >= 32'(MAX_SAMPLES));

   // status 1 and 4 carry zero channels
   assign out_r = (out_status == ST_ACCUM || out_status == ST_LOADED) ? '0 : res_ff[0];
   assign out_g = (out_status == ST_ACCUM || out_status == ST_LOADED) ? '0 : res_ff[1];
   assign out_b = (out_status == ST_ACCUM || out_status == ST_LOADED) ? '0 : res_ff[2];

   `ASSERT_ALWAYS(a_cnt_max, clock, reset, 32'(cnt_ff) <= 32'(MAX_SAMPLES),
      "sample count above limit")
   `ASSERT_NEXT(a_clear, clock, reset, cmd.clear_run, cnt_ff == '0,
      "run not cleared")
endmodule

// ----- hw/rtl/ctpn_control.sv -----
// ----------------------------------------------------------------------------
// ctpn_control
// Sequencer: decodes the opcode and walks the divider over three channels.
// ----------------------------------------------------------------------------
module ctpn_control
   import ctpn_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_BITS-1:0]   req_opcode,
   input  logic                 req_last_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STAT_BITS-1:0] rsp_status,
   output cmd_type              cmd,
   input  sts_type              sts
);
   `include "assert_macros.svh"

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [1:0]           ch_ff, ch_in;
   logic                 avg_ff, avg_in;
   logic                 white_ff, white_in;
   logic [STAT_BITS-1:0] stat_ff, stat_in;
   logic                 accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_status = stat_ff;

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      avg_in   = avg_ff;
      white_in = white_ff;
      stat_in  = stat_ff;
      cmd      = '0;
      cmd.div_ch  = ch_ff;
      cmd.div_avg = avg_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               ch_in    = 2'd0;
               white_in = (req_opcode == OP_WSAMP);
               if (req_opcode == OP_WSAMP || req_opcode == OP_BSAMP) begin
                  cmd.accum = 1'b1;
                  avg_in    = 1'b1;
                  stat_in   = sts.over ? ST_OVER : (req_last_sample ? ST_STORED : ST_ACCUM);
                  state_in  = req_last_sample ? S_DIV : S_OUT;
               end else if (req_opcode == OP_WLOAD || req_opcode == OP_BLOAD) begin
                  cmd.load_w = (req_opcode == OP_WLOAD);
                  cmd.load_b = (req_opcode == OP_BLOAD);
                  stat_in    = ST_LOADED;
                  state_in   = S_OUT;
               end else begin
                  avg_in   = 1'b0;
                  stat_in  = ST_NORM;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            cmd.store_w = avg_ff && white_ff;
            cmd.store_b = avg_ff && !white_ff;
            if (sts.div_done) begin
               if (ch_ff == 2'd2) begin
                  cmd.clear_run = avg_ff;
                  state_in      = S_OUT;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = S_DIV;
               end
            end
         end
         S_OUT: begin
            cmd.out_load = 1'b1;
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ch_ff    <= '0;
         avg_ff   <= 1'b0;
         white_ff <= 1'b0;
         stat_ff  <= ST_NORM;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         avg_ff   <= avg_in;
         white_ff <= white_in;
         stat_ff  <= stat_in;
      end
   end

   `ASSERT_ALWAYS(a_no_accept_busy, clock, reset, !(accept && rsp_valid),
      "transaction accepted while result pending")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_status), "stalled result changed")
endmodule
